/* design/lac_pkg.sv */
// lac_pkg: shared types, register map and codes of the leg actuator controller
// no dependencies
`default_nettype none

package lac_pkg;

	localparam int PositionWidthDef = 16;
	localparam int DivSteps = 24;
	localparam int AddrWidth = 5;
	localparam int DataWidth = 32;

	localparam logic [2:0] REG_SET_VOLTAGE = 3'd0;
	localparam logic [2:0] REG_DEFAULT_DUTY = 3'd1;
	localparam logic [2:0] REG_COAST_TICKS = 3'd2;
	localparam logic [2:0] REG_MIN_SPEED_DUTY = 3'd3;
	localparam logic [2:0] REG_MAX_POSITION = 3'd4;

	localparam logic [1:0] KIND_CMD = 2'd0;
	localparam logic [1:0] KIND_TICK = 2'd1;
	localparam logic [1:0] KIND_ENABLE = 2'd2;

	localparam logic [1:0] REQ_DOWN = 2'd0;
	localparam logic [1:0] REQ_UP = 2'd1;
	localparam logic [1:0] REQ_IDLE = 2'd2;

	localparam logic [1:0] MODE_RUN = 2'd0;
	localparam logic [1:0] MODE_COAST = 2'd1;
	localparam logic [1:0] MODE_BRAKE = 2'd2;

	localparam logic [1:0] STATUS_RUN = 2'd0;
	localparam logic [1:0] STATUS_BOTTOM = 2'd1;
	localparam logic [1:0] STATUS_TOP = 2'd2;
	localparam logic [1:0] STATUS_IDLE = 2'd3;

	localparam logic [1:0] END_NONE = 2'd0;
	localparam logic [1:0] END_BOTTOM = 2'd1;
	localparam logic [1:0] END_TOP = 2'd2;

	localparam logic [6:0] SupplyLowDiv = 7'd100;

	typedef struct packed {
		logic [23:0] set_voltage;
		logic [15:0] default_duty;
		logic [15:0] coast_ticks;
		logic [15:0] min_speed_duty;
		logic [15:0] max_position;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  request;
		logic        down_switch;
		logic        up_switch;
		logic        fault_pin;
		logic [11:0] supply_sample;
	} item_t;

	typedef struct packed {
		logic [1:0]  status_code;
		logic [15:0] duty;
		logic        phase_down;
		logic        decay_high;
		logic        enable_line;
		logic        reset_pulse;
		logic [15:0] position;
		logic        motor_power;
		logic        enabled_now;
	} result_t;

	typedef struct packed {
		logic [23:0] quotient;
		logic [11:0] remainder;
	} div_res_t;

endpackage

`default_nettype wire

/* design/leg_actuator_controller_unit.sv */
// leg_actuator_controller_unit: top level, item sequencing and output register
// down and up commands pass through the 24-step bit-serial divider before the result
// is registered; all other items go straight to the result register
// throughput: one item at a time, next item taken the cycle after the result is registered
// reset: configuration and control registers cleared, motor mode braking, no end latched, output empty
// depends on lac_pkg, lac_apb_regs, lac_serial_div, lac_core
`default_nettype none

module leg_actuator_controller_unit #(
	parameter int POSITION_WIDTH = lac_pkg::PositionWidthDef
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            psel,
	input  wire                            penable,
	input  wire                            pwrite,
	input  wire  [lac_pkg::AddrWidth-1:0]  paddr,
	input  wire  [lac_pkg::DataWidth-1:0]  pwdata,
	output logic [lac_pkg::DataWidth-1:0]  prdata,
	output logic                           pready,
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire  [1:0]                     kind,
	input  wire  [1:0]                     request,
	input  wire                            down_switch,
	input  wire                            up_switch,
	input  wire                            fault_pin,
	input  wire  [11:0]                    supply_sample,
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic [1:0]                     status_code,
	output logic [15:0]                    duty,
	output logic                           phase_down,
	output logic                           decay_high,
	output logic                           enable_line,
	output logic                           reset_pulse,
	output logic [15:0]                    position,
	output logic                           motor_power,
	output logic                           enabled_now
);
	import lac_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0] state_q;
	item_t      item_q, item_in;
	cfg_t       cfg;
	div_res_t   div_res;
	result_t    core_res, res_q;
	logic       div_busy, div_start, accept, commit, needs_div, out_valid_q;

	assign item_in = '{kind: kind, request: request, down_switch: down_switch,
		up_switch: up_switch, fault_pin: fault_pin, supply_sample: supply_sample};
	assign in_stall = state_q != ST_IDLE;
	assign accept = in_valid && !in_stall;
	assign needs_div = (kind == KIND_CMD) && (request == REQ_DOWN || request == REQ_UP);
	assign div_start = accept && needs_div;
	assign commit = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	lac_apb_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	lac_serial_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(cfg.set_voltage),
		.divisor(supply_sample), .busy(div_busy), .res(div_res)
	);

	lac_core #(.POSITION_WIDTH(POSITION_WIDTH)) u_core (
		.clk(clk), .arst_n(arst_n), .commit(commit), .item(item_q),
		.div_res(div_res), .cfg(cfg), .res(core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (accept) begin
					state_q <= needs_div ? ST_DIV : ST_DONE;
				end
				ST_DIV: if (!div_busy) begin
					state_q <= ST_DONE;
				end
				ST_DONE: if (commit) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item_in;
		end
		if (commit) begin
			res_q <= core_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign status_code = res_q.status_code;
	assign duty = res_q.duty;
	assign phase_down = res_q.phase_down;
	assign decay_high = res_q.decay_high;
	assign enable_line = res_q.enable_line;
	assign reset_pulse = res_q.reset_pulse;
	assign position = res_q.position;
	assign motor_power = res_q.motor_power;
	assign enabled_now = res_q.enabled_now;

endmodule

`default_nettype wire

/* design/lac_apb_regs.sv */
// lac_apb_regs: configuration registers behind an apb-style port
// depends on lac_pkg
`default_nettype none

module lac_apb_regs (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               psel,
	input  wire                               penable,
	input  wire                               pwrite,
	input  wire  [lac_pkg::AddrWidth-1:0]     paddr,
	input  wire  [lac_pkg::DataWidth-1:0]     pwdata,
	output logic [lac_pkg::DataWidth-1:0]     prdata,
	output logic                              pready,
	output lac_pkg::cfg_t                     cfg
);
	import lac_pkg::*;

	cfg_t        cfg_q;
	logic [2:0]  idx;
	logic        wr_en;

	assign pready = 1'b1;
	assign idx = paddr[AddrWidth-1:2];
	assign wr_en = psel && penable && pwrite && pready;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_SET_VOLTAGE: cfg_q.set_voltage <= pwdata[23:0];
				REG_DEFAULT_DUTY: cfg_q.default_duty <= pwdata[15:0];
				REG_COAST_TICKS: cfg_q.coast_ticks <= pwdata[15:0];
				REG_MIN_SPEED_DUTY: cfg_q.min_speed_duty <= pwdata[15:0];
				REG_MAX_POSITION: cfg_q.max_position <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SET_VOLTAGE: prdata = {8'd0, cfg_q.set_voltage};
			REG_DEFAULT_DUTY: prdata = {16'd0, cfg_q.default_duty};
			REG_COAST_TICKS: prdata = {16'd0, cfg_q.coast_ticks};
			REG_MIN_SPEED_DUTY: prdata = {16'd0, cfg_q.min_speed_duty};
			REG_MAX_POSITION: prdata = {16'd0, cfg_q.max_position};
			default: prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

/* design/lac_serial_div.sv */
// lac_serial_div: bit-serial restoring divider, one quotient bit per cycle
// depends on lac_pkg
`default_nettype none

module lac_serial_div (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	input  wire  [23:0]       dividend,
	input  wire  [11:0]       divisor,
	output logic              busy,
	output lac_pkg::div_res_t res
);
	import lac_pkg::*;

	localparam int CntWidth = $clog2(DivSteps + 1);

	logic [23:0]         dvd_q;
	logic [11:0]         dsr_q;
	logic [12:0]         rem_q;
	logic [CntWidth-1:0] cnt_q;
	logic                busy_q;
	logic [12:0]         shifted;
	logic                ge;

	assign shifted = {rem_q[11:0], dvd_q[23]};
	assign ge = shifted >= {1'b0, dsr_q};
	assign busy = busy_q;
	assign res.quotient = dvd_q;
	assign res.remainder = rem_q[11:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CntWidth'(DivSteps);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CntWidth'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// shift register walks the dividend out and the quotient in
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[22:0], ge};
			rem_q <= ge ? (shifted - {1'b0, dsr_q}) : shifted;
		end
	end

endmodule

`default_nettype wire

/* design/lac_core.sv */
// lac_core: actuator state, stop and drive rules, tick and enable handling
// depends on lac_pkg; quotient and remainder come from lac_serial_div
`default_nettype none

module lac_core #(
	parameter int POSITION_WIDTH = lac_pkg::PositionWidthDef
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                commit,
	input  lac_pkg::item_t     item,
	input  lac_pkg::div_res_t  div_res,
	input  lac_pkg::cfg_t      cfg,
	output lac_pkg::result_t   res
);
	import lac_pkg::*;

	logic [POSITION_WIDTH-1:0] pos_q, pos_n, maxp;
	logic [1:0]                latch_q, latch_n;
	logic [1:0]                mode_q, mode_n;
	logic [15:0]               cc_q, cc_n;
	logic [15:0]               duty_q, duty_n;
	logic                      phase_q, phase_n;
	logic                      decay_q, decay_n;
	logic                      en_q, en_n;
	logic                      pwr_q, pwr_n;
	logic [1:0]                status;
	logic                      pulse, en_now, drive, stop;
	logic [POSITION_WIDTH+15:0] maxp_ext, pos_ext;
	logic [19:0]               low_thr;
	logic                      supply_low;
	logic                      round_up;
	logic [24:0]               q_round;
	logic [15:0]               comp_duty;

	assign maxp_ext = {{POSITION_WIDTH{1'b0}}, cfg.max_position};
	assign maxp = maxp_ext[POSITION_WIDTH-1:0];
	assign pos_ext = {16'd0, pos_n};

	// supply below set_voltage/100 means set_voltage >= 100 * (supply + 1)
	assign low_thr = 20'(item.supply_sample) * 20'(SupplyLowDiv) + 20'(SupplyLowDiv);
	assign supply_low = (item.supply_sample == 12'd0) || (cfg.set_voltage >= {4'd0, low_thr});
	assign round_up = div_res.remainder > {1'b0, item.supply_sample[11:1]};
	assign q_round = {1'b0, div_res.quotient} + {24'd0, round_up};
	assign comp_duty = supply_low ? cfg.default_duty :
		((|q_round[24:16]) ? 16'hFFFF : q_round[15:0]);

	always_comb begin
		pos_n = pos_q;
		latch_n = latch_q;
		mode_n = mode_q;
		cc_n = cc_q;
		duty_n = duty_q;
		phase_n = phase_q;
		decay_n = decay_q;
		en_n = en_q;
		pwr_n = pwr_q;
		status = STATUS_RUN;
		pulse = 1'b0;
		en_now = 1'b0;
		drive = 1'b0;
		stop = 1'b0;
		case (item.kind)
			KIND_CMD: begin
				case (item.request)
					REQ_DOWN: begin
						if (item.down_switch || latch_q == END_BOTTOM) begin
							latch_n = END_BOTTOM;
							status = STATUS_BOTTOM;
							pos_n = '0;
							stop = 1'b1;
						end else begin
							latch_n = END_NONE;
							phase_n = 1'b1;
							decay_n = 1'b0;
							drive = 1'b1;
						end
					end
					REQ_UP: begin
						if (item.up_switch || latch_q == END_TOP) begin
							latch_n = END_TOP;
							status = STATUS_TOP;
							pos_n = maxp;
							stop = 1'b1;
						end else begin
							latch_n = END_NONE;
							phase_n = 1'b0;
							decay_n = 1'b0;
							drive = 1'b1;
						end
					end
					REQ_IDLE: begin
						status = STATUS_IDLE;
						stop = 1'b1;
					end
					default: ;
				endcase
				if (stop) begin
					en_n = 1'b0;
					if (mode_q == MODE_RUN) begin
						decay_n = 1'b1;
						mode_n = MODE_COAST;
						cc_n = '0;
					end
					if (!(mode_n == MODE_COAST && cc_n < cfg.coast_ticks)) begin
						decay_n = 1'b0;
						mode_n = MODE_BRAKE;
					end
					duty_n = '0;
					pwr_n = 1'b0;
				end else if (drive) begin
					duty_n = comp_duty;
					pulse = !item.fault_pin;
					pwr_n = 1'b1;
				end
			end
			KIND_TICK: begin
				if (cc_q != 16'hFFFF) begin
					cc_n = cc_q + 16'd1;
				end
				if (duty_q > cfg.min_speed_duty) begin
					if (phase_q) begin
						if (pos_q != '0) begin
							pos_n = pos_q - 1'b1;
						end
					end else if (pos_q < maxp) begin
						pos_n = pos_q + 1'b1;
					end
				end
			end
			KIND_ENABLE: begin
				if (en_q) begin
					pulse = !item.fault_pin;
				end else begin
					en_n = 1'b1;
					mode_n = MODE_RUN;
					en_now = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			latch_q <= END_NONE;
			mode_q <= MODE_BRAKE;
			cc_q <= '0;
			duty_q <= '0;
			phase_q <= 1'b0;
			decay_q <= 1'b0;
			en_q <= 1'b0;
			pwr_q <= 1'b0;
		end else if (commit) begin
			pos_q <= pos_n;
			latch_q <= latch_n;
			mode_q <= mode_n;
			cc_q <= cc_n;
			duty_q <= duty_n;
			phase_q <= phase_n;
			decay_q <= decay_n;
			en_q <= en_n;
			pwr_q <= pwr_n;
		end
	end

	always_comb begin
		res.status_code = status;
		res.duty = duty_n;
		res.phase_down = phase_n;
		res.decay_high = decay_n;
		res.enable_line = en_n;
		res.reset_pulse = pulse;
		res.position = pos_ext[15:0];
		res.motor_power = pwr_n;
		res.enabled_now = en_now;
	end

endmodule

`default_nettype wire

/* tb/testbench.sv */
// testbench for leg_actuator_controller_unit: directed and random command, tick and enable items
// against a cycle-free prediction of outputs, with apb setup, random input gaps and random result stalls
// depends on lac_pkg and the leg_actuator_controller_unit rtl
`timescale 1ns / 100ps

module testbench;
	import lac_pkg::*;

	localparam int PosWidth = PositionWidthDef;
	localparam int QuietLimit = 5000;
	localparam int LongHold = 400;
	localparam logic [1:0] REQ_NONE = 2'd3;
	localparam logic [1:0] KIND_SPARE = 2'd3;

	class leg_drive_tracker;
		cfg_t cfg;
		logic [PosWidth-1:0] pos;
		logic [1:0] end_latch;
		logic [1:0] mode;
		logic [15:0] coast;
		logic [15:0] duty;
		logic phase, decay, en, power;
		result_t due_results[$];
		int unsigned mismatches;

		function new();
			cfg = '0;
			pos = '0;
			end_latch = END_NONE;
			mode = MODE_BRAKE;
			coast = '0;
			duty = '0;
			phase = 1'b0;
			decay = 1'b0;
			en = 1'b0;
			power = 1'b0;
			mismatches = 0;
		endfunction

		function void set_register(logic [2:0] idx, logic [31:0] val);
			case (idx)
				REG_SET_VOLTAGE: cfg.set_voltage = val[23:0];
				REG_DEFAULT_DUTY: cfg.default_duty = val[15:0];
				REG_COAST_TICKS: cfg.coast_ticks = val[15:0];
				REG_MIN_SPEED_DUTY: cfg.min_speed_duty = val[15:0];
				REG_MAX_POSITION: cfg.max_position = val[15:0];
				default: ;
			endcase
		endfunction

		function int outstanding();
			return due_results.size();
		endfunction

		function logic [15:0] supply_duty(logic [11:0] supply);
			int unsigned sv, s, q, r;
			sv = 32'(cfg.set_voltage);
			s = 32'(supply);
			if (s == 0 || s < sv / SupplyLowDiv)
				return cfg.default_duty;
			q = sv / s;
			r = sv % s;
			if (r > s / 2)
				q++;
			return (q > 32'hFFFF) ? 16'hFFFF : q[15:0];
		endfunction

		function void halt_motor();
			en = 1'b0;
			if (mode == MODE_RUN) begin
				decay = 1'b1;
				mode = MODE_COAST;
				coast = '0;
			end
			if (mode == MODE_COAST && coast < cfg.coast_ticks)
				return;
			decay = 1'b0;
			mode = MODE_BRAKE;
		endfunction

		function void take_item(item_t it);
			result_t r;
			logic stop, drive;
			logic [PosWidth-1:0] maxp;
			r = '0;
			stop = 1'b0;
			drive = 1'b0;
			maxp = PosWidth'(cfg.max_position);
			case (it.kind)
				KIND_CMD: begin
					if (it.request == REQ_DOWN) begin
						if (it.down_switch || end_latch == END_BOTTOM) begin
							end_latch = END_BOTTOM;
							r.status_code = STATUS_BOTTOM;
							pos = '0;
							stop = 1'b1;
						end else begin
							end_latch = END_NONE;
							phase = 1'b1;
							decay = 1'b0;
							drive = 1'b1;
						end
					end else if (it.request == REQ_UP) begin
						if (it.up_switch || end_latch == END_TOP) begin
							end_latch = END_TOP;
							r.status_code = STATUS_TOP;
							pos = maxp;
							stop = 1'b1;
						end else begin
							end_latch = END_NONE;
							phase = 1'b0;
							decay = 1'b0;
							drive = 1'b1;
						end
					end else if (it.request == REQ_IDLE) begin
						r.status_code = STATUS_IDLE;
						stop = 1'b1;
					end
					if (stop) begin
						halt_motor();
						duty = '0;
						power = 1'b0;
					end else if (drive) begin
						duty = supply_duty(it.supply_sample);
						r.reset_pulse = !it.fault_pin;
						power = 1'b1;
					end
				end
				KIND_TICK: begin
					if (coast < 16'hFFFF)
						coast++;
					if (duty > cfg.min_speed_duty) begin
						if (phase) begin
							if (pos > 0)
								pos--;
						end else if (pos < maxp) begin
							pos++;
						end
					end
				end
				KIND_ENABLE: begin
					if (en) begin
						r.reset_pulse = !it.fault_pin;
					end else begin
						en = 1'b1;
						mode = MODE_RUN;
						r.enabled_now = 1'b1;
					end
				end
				default: ;
			endcase
			r.duty = duty;
			r.phase_down = phase;
			r.decay_high = decay;
			r.enable_line = en;
			r.position = 16'(pos);
			r.motor_power = power;
			due_results.push_back(r);
		endfunction

		function void check_field(string name, int unsigned exp_v, int unsigned got_v);
			if (exp_v != got_v) begin
				mismatches++;
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
			end
		endfunction

		function void match_result(result_t got);
			result_t e;
			if (due_results.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, got %h", $time, got);
				return;
			end
			e = due_results.pop_front();
			check_field("status_code", 32'(e.status_code), 32'(got.status_code));
			check_field("duty", 32'(e.duty), 32'(got.duty));
			check_field("phase_down", 32'(e.phase_down), 32'(got.phase_down));
			check_field("decay_high", 32'(e.decay_high), 32'(got.decay_high));
			check_field("enable_line", 32'(e.enable_line), 32'(got.enable_line));
			check_field("reset_pulse", 32'(e.reset_pulse), 32'(got.reset_pulse));
			check_field("position", 32'(e.position), 32'(got.position));
			check_field("motor_power", 32'(e.motor_power), 32'(got.motor_power));
			check_field("enabled_now", 32'(e.enabled_now), 32'(got.enabled_now));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [AddrWidth-1:0] paddr;
	logic [DataWidth-1:0] pwdata;
	logic [DataWidth-1:0] prdata;
	logic pready;
	logic in_valid, in_stall;
	logic [1:0] kind, request;
	logic down_switch, up_switch, fault_pin;
	logic [11:0] supply_sample;
	logic out_valid, out_stall;
	logic [1:0] status_code;
	logic [15:0] duty;
	logic phase_down, decay_high, enable_line, reset_pulse;
	logic [15:0] position;
	logic motor_power, enabled_now;

	leg_drive_tracker tracker;
	bit calm;
	bit hold_long;
	int quiet_cycles;

	leg_actuator_controller_unit dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .request(request), .down_switch(down_switch),
		.up_switch(up_switch), .fault_pin(fault_pin), .supply_sample(supply_sample),
		.out_valid(out_valid), .out_stall(out_stall),
		.status_code(status_code), .duty(duty), .phase_down(phase_down),
		.decay_high(decay_high), .enable_line(enable_line), .reset_pulse(reset_pulse),
		.position(position), .motor_power(motor_power), .enabled_now(enabled_now)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				tracker.take_item({kind, request, down_switch, up_switch, fault_pin,
					supply_sample});
			if (out_valid && !out_stall)
				tracker.match_result({status_code, duty, phase_down, decay_high,
					enable_line, reset_pulse, position, motor_power, enabled_now});
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(psel && penable)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QuietLimit) begin
				$display("testbench: FAIL");
				$finish;
			end
		end
	end

	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 4);
		if (r < 97)
			return $urandom_range(5, 15);
		return $urandom_range(30, 90);
	endfunction

	// result side: random stall stretches, one long hold on request
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (hold_long) begin
				hold_long = 1'b0;
				out_stall <= 1'b1;
				repeat (LongHold) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				n = pause_len();
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
				out_stall <= 1'b0;
			end
			repeat ($urandom_range(0, 6)) @(posedge clk);
		end
	end

	function automatic item_t make_item(logic [1:0] k, logic [1:0] rq, logic dsw, logic usw,
			logic fp, logic [11:0] s);
		item_t it;
		it.kind = k;
		it.request = rq;
		it.down_switch = dsw;
		it.up_switch = usw;
		it.fault_pin = fp;
		it.supply_sample = s;
		return it;
	endfunction

	task automatic send_item(item_t it);
		int gap;
		gap = pause_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= it.kind;
		request <= it.request;
		down_switch <= it.down_switch;
		up_switch <= it.up_switch;
		fault_pin <= it.fault_pin;
		supply_sample <= it.supply_sample;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (tracker.outstanding() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		tracker.set_register(idx, val);
	endtask

	task automatic configure(logic [23:0] sv, logic [15:0] dd, logic [15:0] ct,
			logic [15:0] msd, logic [15:0] mp);
		drain();
		cfg_write(REG_SET_VOLTAGE, 32'(sv));
		cfg_write(REG_DEFAULT_DUTY, 32'(dd));
		cfg_write(REG_COAST_TICKS, 32'(ct));
		cfg_write(REG_MIN_SPEED_DUTY, 32'(msd));
		cfg_write(REG_MAX_POSITION, 32'(mp));
	endtask

	task automatic random_phase(int count, int hold_at, int pause_at);
		item_t it;
		int r;
		for (int i = 0; i < count; i++) begin
			if (i == hold_at)
				hold_long = 1'b1;
			if (i == pause_at)
				drain();
			r = $urandom_range(0, 99);
			if (r < 45)
				it.kind = KIND_CMD;
			else if (r < 85)
				it.kind = KIND_TICK;
			else if (r < 97)
				it.kind = KIND_ENABLE;
			else
				it.kind = KIND_SPARE;
			it.request = 2'($urandom_range(0, 3));
			it.down_switch = ($urandom_range(0, 7) == 0);
			it.up_switch = ($urandom_range(0, 7) == 0);
			it.fault_pin = ($urandom_range(0, 4) != 0);
			r = $urandom_range(0, 9);
			if (r == 0)
				it.supply_sample = '0;
			else if (r < 4)
				it.supply_sample = 12'($urandom_range(1, 63));
			else
				it.supply_sample = 12'($urandom_range(0, 4095));
			send_item(it);
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		kind = KIND_TICK;
		request = REQ_NONE;
		down_switch = 1'b0;
		up_switch = 1'b0;
		fault_pin = 1'b1;
		supply_sample = '0;
		out_stall = 1'b0;
		calm = 1'b0;
		hold_long = 1'b0;
		quiet_cycles = 0;
		tracker = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: supply low threshold 3000, min speed 80, short travel
		configure(24'd300000, 16'd500, 16'd2, 16'd80, 16'd3);
		send_item(make_item(KIND_TICK, REQ_NONE, 1'b0, 1'b0, 1'b1, 12'd0));
		send_item(make_item(KIND_ENABLE, REQ_NONE, 1'b0, 1'b0, 1'b1, 12'd0));
		send_item(make_item(KIND_ENABLE, REQ_NONE, 1'b0, 1'b0, 1'b0, 12'd0));
		send_item(make_item(KIND_CMD, REQ_DOWN, 1'b0, 1'b0, 1'b0, 12'd0));
		send_item(make_item(KIND_TICK, REQ_NONE, 1'b0, 1'b0, 1'b1, 12'd0));
		send_item(make_item(KIND_CMD, REQ_UP, 1'b0, 1'b0, 1'b1, 12'd3000));
		repeat (4) send_item(make_item(KIND_TICK, REQ_NONE, 1'b0, 1'b0, 1'b1, 12'd0));
		send_item(make_item(KIND_CMD, REQ_UP, 1'b0, 1'b0, 1'b1, 12'd4095));
		send_item(make_item(KIND_TICK, REQ_NONE, 1'b0, 1'b0, 1'b1, 12'd0));
		send_item(make_item(KIND_CMD, REQ_UP, 1'b0, 1'b1, 1'b1, 12'd3000));
		send_item(make_item(KIND_CMD, REQ_IDLE, 1'b0, 1'b0, 1'b1, 12'd3000));
		repeat (2) send_item(make_item(KIND_TICK, REQ_NONE, 1'b0, 1'b0, 1'b1, 12'd0));
		send_item(make_item(KIND_CMD, REQ_IDLE, 1'b0, 1'b0, 1'b1, 12'd3000));
		send_item(make_item(KIND_CMD, REQ_UP, 1'b0, 1'b0, 1'b1, 12'd3000));
		send_item(make_item(KIND_CMD, REQ_DOWN, 1'b0, 1'b0, 1'b1, 12'd2999));
		send_item(make_item(KIND_CMD, REQ_DOWN, 1'b1, 1'b0, 1'b0, 12'd3000));
		send_item(make_item(KIND_CMD, REQ_DOWN, 1'b0, 1'b0, 1'b1, 12'd3000));
		send_item(make_item(KIND_CMD, REQ_NONE, 1'b1, 1'b1, 1'b0, 12'd4095));
		send_item(make_item(KIND_SPARE, REQ_DOWN, 1'b1, 1'b1, 1'b0, 12'd4095));
		send_item(make_item(KIND_CMD, REQ_UP, 1'b1, 1'b1, 1'b1, 12'd3000));
		send_item(make_item(KIND_ENABLE, REQ_NONE, 1'b0, 1'b0, 1'b0, 12'd0));
		send_item(make_item(KIND_CMD, REQ_DOWN, 1'b1, 1'b1, 1'b1, 12'd3000));

		// long coast: coasting holds through a run of ticks
		calm = 1'b1;
		configure(24'd300000, 16'd500, 16'hFFFF, 16'd80, 16'd200);
		send_item(make_item(KIND_ENABLE, REQ_NONE, 1'b0, 1'b0, 1'b1, 12'd0));
		send_item(make_item(KIND_CMD, REQ_DOWN, 1'b0, 1'b0, 1'b1, 12'd3000));
		send_item(make_item(KIND_CMD, REQ_IDLE, 1'b0, 1'b0, 1'b1, 12'd0));
		repeat (20) send_item(make_item(KIND_TICK, REQ_NONE, 1'b0, 1'b0, 1'b1, 12'd0));
		send_item(make_item(KIND_CMD, REQ_IDLE, 1'b0, 1'b0, 1'b1, 12'd0));
		calm = 1'b0;

		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 0)
				configure('0, '0, '0, '0, '0);
			else if (ph == 1)
				configure(24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
			else
				configure(($urandom_range(0, 3) == 0) ? 24'($urandom_range(0, 24'hFFFFFF))
						: 24'($urandom_range(1000, 400000)),
					16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 5)),
					16'($urandom_range(0, 300)),
					($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 16'hFFFF))
						: 16'($urandom_range(0, 60)));
			calm = (ph == 2);
			random_phase(225, (ph == 4) ? 50 : -1, (ph == 6) ? 100 : -1);
		end
		calm = 1'b0;

		drain();
		repeat (40) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.outstanding() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
